/* src/assert_macros.svh */
// assertion macros shared by the parser modules
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check, off during reset
`define BMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication check, off during reset
`define BMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* src/bmp_pkg.sv */
// types, constants and helpers for the ble-midi packet parser
// no dependencies
`timescale 1ns / 1ps

package bmp_pkg;

    localparam int MSG_DEPTH  = 64;
    localparam int PACKET_MAX = 512;

    localparam int IDX_W  = $clog2(MSG_DEPTH);
    localparam int FILL_W = $clog2(MSG_DEPTH + 1);
    localparam int PLEN_W = 10;
    localparam int TS_W   = 13;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] MIN_LEN_RESET = CFG_W'(3);

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] REALTIME_LO = 8'hF8;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_NO_STATUS  = 2'd1,
        ERR_BAD_HEADER = 2'd2,
        ERR_SHORT      = 2'd3
    } err_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } ctrl_state_t;

    typedef struct packed {
        logic              cmd;
        logic [7:0]        rx_byte;
        logic              first_in_packet;
        logic [PLEN_W-1:0] packet_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0]      msg_byte;
        logic [TS_W-1:0] msg_timestamp;
        logic            last_of_message;
        logic [1:0]      err_code;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic load_run;
        logic idx_inc;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic run_start;
        logic out_free;
        logic emit_last;
    } dp_status_t;

    // number of data bytes that follow a status byte
    function automatic logic [1:0] data_len_of(input logic [7:0] s);
        logic [1:0] n;
        n = 2'd0;
        if (!s[7])
            n = 2'd0;
        else if (s[7:4] == 4'hC || s[7:4] == 4'hD)
            n = 2'd1;
        else if (s[7:4] != 4'hF)
            n = 2'd2;
        else if (s == 8'hF1 || s == 8'hF3)
            n = 2'd1;
        else if (s == 8'hF2)
            n = 2'd2;
        return n;
    endfunction

endpackage

/* src/bmp_ctrl.sv */
// controller for the ble-midi parser: item acceptance and message run sequencing
// depends on bmp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bmp_pkg::dp_status_t status,
    output bmp_pkg::ctrl_cmd_t  cmd
);
    import bmp_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.out_free && status.run_start)
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (status.out_free)
                    state_next = status.emit_last ? ST_IDLE : ST_READ;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = !status.out_free;
                cmd.accept = in_valid && status.out_free;
            end
            ST_READ:
                cmd.rd_en = 1'b1;
            ST_LOAD:
            begin
                cmd.load_run = status.out_free;
                cmd.idx_inc  = status.out_free && !status.emit_last;
            end
            default:
                in_stall = 1'b1;
        endcase
    end

    `BMP_ASSERT_IMP(a_read_then_load, state_reg == ST_READ, ##1 state_reg == ST_LOAD,
        "read not followed by load")
    `BMP_ASSERT_IMP(a_stall_in_run, state_reg != ST_IDLE, in_stall,
        "request taken during message run")
    `BMP_ASSERT_IMP(a_accept_in_idle, cmd.accept, state_reg == ST_IDLE,
        "request accepted outside idle")

endmodule

/* src/bmp_datapath.sv */
// datapath for the ble-midi parser: packet and midi state, message store, output register
// depends on bmp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmp_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bmp_pkg::in_item_t         in_data,
    input  logic                      out_stall,
    output logic                      out_valid,
    output bmp_pkg::out_item_t        out_data,
    input  logic                      cfg_we,
    input  logic [bmp_pkg::CFG_W-1:0] cfg_data,
    input  bmp_pkg::ctrl_cmd_t        cmd,
    output bmp_pkg::dp_status_t       status
);
    import bmp_pkg::*;

    logic [7:0] store_mem [MSG_DEPTH];

    logic [CFG_W-1:0]  min_len_reg;
    logic [7:0]        rs_reg, rs_next;
    logic [1:0]        exp_reg, exp_next;
    logic [1:0]        rcv_reg, rcv_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              sysex_reg, sysex_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic              after_ts_reg, after_ts_next;
    logic              dropped_reg, dropped_next;
    logic [7:0]        head_reg, head_next;
    logic [FILL_W-1:0] emit_len_reg, emit_len_next;
    logic [IDX_W-1:0]  emit_idx_reg;
    logic [7:0]        rdata_reg;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic              single;
    logic [7:0]        single_byte;
    err_code_t         single_err;
    logic              run;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [7:0]        wr_data;
    logic              load_single;

    // decode one request against the current state
    always_comb
    begin
        logic [7:0]        b;
        logic [FILL_W-1:0] f;
        logic [1:0]        e;
        logic [1:0]        r;
        b = in_data.rx_byte;
        f = fill_reg;
        e = exp_reg;
        r = rcv_reg;

        rs_next       = rs_reg;
        exp_next      = exp_reg;
        rcv_next      = rcv_reg;
        fill_next     = fill_reg;
        sysex_next    = sysex_reg;
        ts_next       = ts_reg;
        after_ts_next = after_ts_reg;
        dropped_next  = dropped_reg;
        head_next     = head_reg;
        emit_len_next = emit_len_reg;
        single        = 1'b0;
        single_byte   = 8'd0;
        single_err    = ERR_NONE;
        run           = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = fill_reg[IDX_W-1:0];
        wr_data       = b;

        if (in_data.cmd)
        begin
            rs_next       = 8'd0;
            exp_next      = 2'd0;
            rcv_next      = 2'd0;
            fill_next     = '0;
            sysex_next    = 1'b0;
            after_ts_next = 1'b0;
            dropped_next  = 1'b0;
        end
        else if (in_data.first_in_packet)
        begin
            if (in_data.packet_length < PLEN_W'(min_len_reg)
                || in_data.packet_length > PLEN_W'(PACKET_MAX))
            begin
                dropped_next = 1'b1;
                single       = 1'b1;
                single_err   = ERR_SHORT;
            end
            else if (!b[7])
            begin
                dropped_next = 1'b1;
                single       = 1'b1;
                single_err   = ERR_BAD_HEADER;
            end
            else
            begin
                dropped_next  = 1'b0;
                after_ts_next = 1'b0;
                ts_next       = {b[5:0], 7'd0};
            end
        end
        else if (dropped_reg)
        begin
            single = 1'b0;
        end
        else if (b[7] && !after_ts_reg)
        begin
            ts_next       = {ts_reg[TS_W-1:7], b[6:0]};
            after_ts_next = 1'b1;
        end
        else
        begin
            after_ts_next = 1'b0;
            if (b[7])
            begin
                if (b >= REALTIME_LO)
                begin
                    single      = 1'b1;
                    single_byte = b;
                end
                else if (b == SYSEX_END)
                begin
                    if (sysex_reg)
                    begin
                        wr_en = 1'b1;
                        if (fill_reg < FILL_W'(MSG_DEPTH))
                        begin
                            emit_len_next = fill_reg + FILL_W'(1);
                        end
                        else
                        begin
                            wr_addr       = IDX_W'(MSG_DEPTH - 1);
                            emit_len_next = FILL_W'(MSG_DEPTH);
                        end
                        run        = 1'b1;
                        sysex_next = 1'b0;
                        fill_next  = '0;
                    end
                end
                else
                begin
                    sysex_next = 1'b0;
                    exp_next   = 2'd0;
                    rcv_next   = 2'd0;
                    head_next  = b;
                    fill_next  = FILL_W'(1);
                    if (b == SYSEX_START)
                    begin
                        rs_next    = 8'd0;
                        sysex_next = 1'b1;
                    end
                    else
                    begin
                        rs_next  = (b >= SYSEX_START) ? 8'd0 : b;
                        exp_next = data_len_of(b);
                        if (data_len_of(b) == 2'd0)
                        begin
                            fill_next   = '0;
                            single      = 1'b1;
                            single_byte = b;
                        end
                    end
                end
            end
            else if (sysex_reg)
            begin
                if (fill_reg < FILL_W'(MSG_DEPTH))
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            else if (exp_reg == 2'd0 && rs_reg == 8'd0)
            begin
                single     = 1'b1;
                single_err = ERR_NO_STATUS;
            end
            else
            begin
                // running status reuses the stored channel status as head
                if (exp_reg == 2'd0)
                begin
                    e         = data_len_of(rs_reg);
                    r         = 2'd0;
                    head_next = rs_reg;
                    f         = FILL_W'(1);
                end
                wr_addr = f[IDX_W-1:0];
                if (f < FILL_W'(MSG_DEPTH))
                begin
                    wr_en = 1'b1;
                    f     = f + FILL_W'(1);
                end
                r = r + 2'd1;
                if (r >= e)
                begin
                    run           = 1'b1;
                    emit_len_next = f;
                    exp_next      = 2'd0;
                    rcv_next      = 2'd0;
                    fill_next     = '0;
                end
                else
                begin
                    exp_next  = e;
                    rcv_next  = r;
                    fill_next = f;
                end
            end
        end
    end

    assign load_single = cmd.accept && single;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load_single)
        begin
            out_next.msg_byte        = single_byte;
            out_next.msg_timestamp   = ts_reg;
            out_next.last_of_message = 1'b1;
            out_next.err_code        = single_err;
            out_valid_next           = 1'b1;
        end
        else if (cmd.load_run)
        begin
            out_next.msg_byte        = (emit_idx_reg == '0) ? head_reg : rdata_reg;
            out_next.msg_timestamp   = ts_reg;
            out_next.last_of_message = status.emit_last;
            out_next.err_code        = ERR_NONE;
            out_valid_next           = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg   <= MIN_LEN_RESET;
            rs_reg        <= 8'd0;
            exp_reg       <= 2'd0;
            rcv_reg       <= 2'd0;
            fill_reg      <= '0;
            sysex_reg     <= 1'b0;
            ts_reg        <= '0;
            after_ts_reg  <= 1'b0;
            dropped_reg   <= 1'b0;
            emit_len_reg  <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                min_len_reg <= cfg_data;
            if (cmd.accept)
            begin
                rs_reg       <= rs_next;
                exp_reg      <= exp_next;
                rcv_reg      <= rcv_next;
                fill_reg     <= fill_next;
                sysex_reg    <= sysex_next;
                ts_reg       <= ts_next;
                after_ts_reg <= after_ts_next;
                dropped_reg  <= dropped_next;
                if (run)
                begin
                    emit_len_reg <= emit_len_next;
                    emit_idx_reg <= '0;
                end
            end
            else if (cmd.idx_inc)
            begin
                emit_idx_reg <= emit_idx_reg + IDX_W'(1);
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            head_reg <= head_next;
        out_reg <= out_next;
    end

    // message store, entry zero lives in head_reg
    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
            store_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rdata_reg <= store_mem[emit_idx_reg];
    end

    assign status.run_start = run;
    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.emit_last = ({1'b0, emit_idx_reg} + FILL_W'(1)) == emit_len_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `BMP_ASSERT_IMP(a_no_overwrite, load_single || cmd.load_run,
        !out_valid_reg || !out_stall, "output register overwritten while stalled")
    `BMP_ASSERT_IMP(a_idx_in_run, cmd.rd_en, {1'b0, emit_idx_reg} < emit_len_reg,
        "store read past message length")
    `BMP_ASSERT(a_fill_bound, fill_reg <= FILL_W'(MSG_DEPTH),
        "message fill beyond store depth")

endmodule

/* src/ble_midi_packet_message_parser.sv */
// one request per cycle at most, none while the output stalls or a message is read out;
// a request with no result or a single result is done when taken, and that result appears
// in the output register on the next cycle; a completed message is read from the store
// byte by byte: registered read (ST_READ), then output load (ST_LOAD), which waits
// on out_stall; async active-low reset clears the parser state, counters and out_valid;
// the message store, head_reg and out_data are not cleared; the store needs no clearing
`timescale 1ns / 1ps

module ble_midi_packet_message_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  bmp_pkg::in_item_t         in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output bmp_pkg::out_item_t        out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bmp_pkg::CFG_W-1:0] cfg_data
);
    import bmp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    bmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bmp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
